### rtl/vector_distance_engine_defines.svh
// Assertion macros shared by the vector distance engine checkers.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef VECTOR_DISTANCE_ENGINE_DEFINES_SVH
`define VECTOR_DISTANCE_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define VDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define VDE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/vde_pkg.sv
// Package for the vector distance engine: widths, metric codes, limits.
// No dependencies; used by vde_isqrt, vde_div and the engine top level.
package vde_pkg;

  localparam int COORD_W  = 16;
  localparam int SUM_W    = 48;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int FRAC_W   = 12;
  localparam int DVD_W    = SUM_W + FRAC_W;
  localparam int MUL_W    = ROOT_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DIST_W   = 32;
  localparam int MAX_DIM  = 4096;
  localparam int CNT_W    = $clog2(MAX_DIM + 1);
  localparam int SQ_CNT_W = $clog2(ROOT_W);
  localparam int DV_CNT_W = $clog2(DVD_W);

  localparam logic [1:0] METRIC_L2  = 2'd0;
  localparam logic [1:0] METRIC_COS = 2'd1;
  localparam logic [1:0] METRIC_MAN = 2'd2;
  localparam logic [1:0] METRIC_NONE = 2'd3;

  localparam logic [DIST_W-1:0] ONE_Q12 = DIST_W'(1) << FRAC_W;
  localparam logic [DIST_W-1:0] TWO_Q12 = DIST_W'(2) << FRAC_W;

  // Start request to an iterative unit
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] operand;
  } unit_req_t;

endpackage

### rtl/vde_isqrt.sv
// Iterative integer square root, two radicand bits per cycle, floor result.
// Depends on vde_pkg.
module vde_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [vde_pkg::SUM_W-1:0]     radicand,
  output logic                          done,
  output logic [vde_pkg::ROOT_W-1:0]    root
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [vde_pkg::SQ_CNT_W-1:0]  step_r, step_nxt;
  logic [vde_pkg::SUM_W-1:0]     x_r, x_nxt;
  logic [vde_pkg::ROOT_W+1:0]    rem_r, rem_nxt;
  logic [vde_pkg::ROOT_W-1:0]    root_r, root_nxt;
  logic [vde_pkg::ROOT_W+3:0]    rem_t;
  logic [vde_pkg::ROOT_W+3:0]    trial;

  assign rem_t = {rem_r, x_r[vde_pkg::SUM_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};

  // One digit of the root per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      x_nxt = x_r << 2;
      if (rem_t >= trial) begin
        rem_nxt  = (vde_pkg::ROOT_W+2)'(rem_t - trial);
        root_nxt = {root_r[vde_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_t[vde_pkg::ROOT_W+1:0];
        root_nxt = {root_r[vde_pkg::ROOT_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == vde_pkg::SQ_CNT_W'(vde_pkg::ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/vde_div.sv
// Iterative restoring divider, one quotient bit per cycle, truncating.
// Depends on vde_pkg.
module vde_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vde_pkg::unit_req_t          req,
  input  logic [vde_pkg::SUM_W-1:0]   divisor,
  output logic                        done,
  output logic [vde_pkg::DVD_W-1:0]   quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [vde_pkg::DV_CNT_W-1:0]  step_r, step_nxt;
  logic [vde_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [vde_pkg::SUM_W-1:0]     dvs_r, dvs_nxt;
  logic [vde_pkg::SUM_W-1:0]     rem_r, rem_nxt;
  logic [vde_pkg::DVD_W-1:0]     quo_r, quo_nxt;
  logic [vde_pkg::SUM_W:0]       rem_t;

  assign rem_t = {rem_r, dvd_r[vde_pkg::DVD_W-1]};

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = req.operand;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_nxt = vde_pkg::SUM_W'(rem_t - {1'b0, dvs_r});
        quo_nxt = {quo_r[vde_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_t[vde_pkg::SUM_W-1:0];
        quo_nxt = {quo_r[vde_pkg::DVD_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == vde_pkg::DV_CNT_W'(vde_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/vector_distance_engine.sv
// Vector distance engine top: sequencer, shared multiplier, running sums.
// Depends on vde_pkg, vde_isqrt and vde_div.
//
//  channel | ports                        | beat contents
//  --------+------------------------------+-----------------------------------
//  input   | in_tvalid/in_tready          | coord_a, coord_b in tdata; tlast
//  result  | out_tvalid/out_tready        | distance in tdata; zero_norm tuser
//  config  | cfg_wr_en/cfg_wr_data        | metric
//
// Each pair steps ST_MUL_AA, ST_MUL_BB, ST_MUL_T, ST_ACC_T: one shared 25x25
// multiplier forms a*a, b*b, then (a-b)^2 for L2 or a*b (Manhattan adds |a-b|);
// pairs past MAX_DIM drop. A last pair adds: L2 a root (one root digit a cycle),
// cosine two roots and a divide, Manhattan, zero norm and unused metric ST_FIN.
// rst_n is synchronous and clears the sums and metric. A result waits in the
// output register while new pairs are taken; stall only when the next is ready.
module vector_distance_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [15:0] coord_a, [31:16] coord_b
  input  logic        in_tlast,    // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] distance
  output logic        out_tuser,   // [0] zero_norm
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data  // metric
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_AA = 4'd1;
  localparam logic [3:0] ST_MUL_BB = 4'd2;
  localparam logic [3:0] ST_MUL_T  = 4'd3;
  localparam logic [3:0] ST_ACC_T  = 4'd4;
  localparam logic [3:0] ST_FIN    = 4'd5;
  localparam logic [3:0] ST_SQ_L2  = 4'd6;
  localparam logic [3:0] ST_SQ_A   = 4'd7;
  localparam logic [3:0] ST_SQ_B   = 4'd8;
  localparam logic [3:0] ST_DIV    = 4'd9;
  localparam logic [3:0] ST_DIV_W  = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  localparam int CW = vde_pkg::COORD_W;
  localparam int SW = vde_pkg::SUM_W;
  localparam int RW = vde_pkg::ROOT_W;
  localparam int MW = vde_pkg::MUL_W;
  localparam int DW = vde_pkg::DIST_W;

  logic [3:0]                 state_r, state_nxt;
  logic [1:0]                 metric_r;
  logic signed [CW-1:0]       a_r, b_r;
  logic                       last_r;
  logic [SW-1:0]              main_r, main_nxt;
  logic [SW-1:0]              na_r, na_nxt;
  logic [SW-1:0]              nb_r, nb_nxt;
  logic [vde_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic signed [2*MW-1:0]     prod_r;
  logic signed [MW-1:0]       mul_x, mul_y;
  logic [RW-1:0]              root_a_r, root_a_nxt;
  logic [DW-1:0]              dist_r, dist_nxt;
  logic                       zn_r, zn_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [DW-1:0]              out_data_r;
  logic                       out_user_r;
  logic                       load_out;
  logic                       in_beat;
  logic signed [CW:0]         diff;
  logic [CW:0]                diff_abs;
  logic [SW-1:0]              prod_lo;
  logic [SW-1:0]              dot_mag;
  logic                       sq_start;
  logic [SW-1:0]              sq_in;
  logic                       sq_done;
  logic [RW-1:0]              sq_root;
  vde_pkg::unit_req_t         div_req;
  logic                       div_done;
  logic [vde_pkg::DVD_W-1:0]  div_q;
  logic                       q_big;
  logic [DW-1:0]              q_low;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign diff      = {a_r[CW-1], a_r} - {b_r[CW-1], b_r};
  assign diff_abs  = diff[CW] ? (CW+1)'(-diff) : diff;
  assign prod_lo   = prod_r[SW-1:0];
  assign dot_mag   = main_r[SW-1] ? SW'(-main_r) : main_r;
  assign q_big     = (div_q >= vde_pkg::DVD_W'(vde_pkg::ONE_Q12));
  assign q_low     = DW'(div_q[vde_pkg::FRAC_W:0]);
  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  vde_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  vde_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .divisor  (prod_lo),
    .done     (div_done),
    .quotient (div_q)
  );

  // Pick operands of the shared multiplier by step
  always_comb begin
    mul_x = MW'(a_r);
    mul_y = MW'(a_r);
    unique case (state_r)
      ST_MUL_BB: begin
        mul_x = MW'(b_r);
        mul_y = MW'(b_r);
      end
      ST_MUL_T: begin
        if (metric_r == vde_pkg::METRIC_L2) begin
          mul_x = MW'(diff);
          mul_y = MW'(diff);
        end else begin
          mul_x = MW'(a_r);
          mul_y = MW'(b_r);
        end
      end
      ST_SQ_B: begin
        mul_x = {1'b0, root_a_r};
        mul_y = {1'b0, sq_root};
      end
      default: begin
        mul_x = MW'(a_r);
        mul_y = MW'(a_r);
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    main_nxt      = main_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    cnt_nxt       = cnt_r;
    root_a_nxt    = root_a_r;
    dist_nxt      = dist_r;
    zn_nxt        = zn_r;
    sq_start      = 1'b0;
    sq_in         = main_r;
    div_req.start   = 1'b0;
    div_req.operand = {dot_mag, {vde_pkg::FRAC_W{1'b0}}};
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (cnt_r < vde_pkg::CNT_W'(vde_pkg::MAX_DIM)) begin
            state_nxt = ST_MUL_AA;
          end else if (in_tlast) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MUL_AA: state_nxt = ST_MUL_BB;
      ST_MUL_BB: begin
        na_nxt    = na_r + prod_lo;
        state_nxt = ST_MUL_T;
      end
      ST_MUL_T: begin
        nb_nxt    = nb_r + prod_lo;
        state_nxt = ST_ACC_T;
      end
      ST_ACC_T: begin
        case (metric_r) inside
          vde_pkg::METRIC_L2, vde_pkg::METRIC_COS: main_nxt = main_r + prod_lo;
          vde_pkg::METRIC_MAN: main_nxt = main_r + SW'(diff_abs);
          default: main_nxt = main_r;
        endcase
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        dist_nxt = '0;
        zn_nxt   = 1'b0;
        case (metric_r)
          vde_pkg::METRIC_L2: begin
            sq_start  = 1'b1;
            sq_in     = main_r;
            state_nxt = ST_SQ_L2;
          end
          vde_pkg::METRIC_COS: begin
            if (na_r == '0 || nb_r == '0) begin
              zn_nxt    = 1'b1;
              state_nxt = ST_OUT;
            end else begin
              sq_start  = 1'b1;
              sq_in     = na_r;
              state_nxt = ST_SQ_A;
            end
          end
          vde_pkg::METRIC_MAN: begin
            dist_nxt  = (main_r[SW-1:DW] != '0) ? '1 : main_r[DW-1:0];
            state_nxt = ST_OUT;
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_SQ_L2: begin
        if (sq_done) begin
          dist_nxt  = DW'(sq_root);
          state_nxt = ST_OUT;
        end
      end
      ST_SQ_A: begin
        if (sq_done) begin
          root_a_nxt = sq_root;
          sq_start   = 1'b1;
          sq_in      = nb_r;
          state_nxt  = ST_SQ_B;
        end
      end
      ST_SQ_B: begin
        if (sq_done) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (div_done) begin
          if (main_r[SW-1]) begin
            dist_nxt = q_big ? vde_pkg::TWO_Q12 : vde_pkg::ONE_Q12 + q_low;
          end else begin
            dist_nxt = q_big ? '0 : vde_pkg::ONE_Q12 - q_low;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          main_nxt  = '0;
          na_nxt    = '0;
          nb_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      metric_r    <= vde_pkg::METRIC_L2;
      main_r      <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      main_r      <= main_nxt;
      na_r        <= na_nxt;
      nb_r        <= nb_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) metric_r <= cfg_wr_data;
    end
    if (in_beat) begin
      a_r    <= in_tdata[CW-1:0];
      b_r    <= in_tdata[2*CW-1:CW];
      last_r <= in_tlast;
    end
    prod_r   <= mul_x * mul_y;
    root_a_r <= root_a_nxt;
    dist_r   <= dist_nxt;
    zn_r     <= zn_nxt;
    if (load_out) begin
      out_data_r <= dist_r;
      out_user_r <= zn_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/vde_checker.sv
// Port-level checks for the vector distance engine, bound to the top level.
// Depends on vector_distance_engine_defines.svh.
`include "vector_distance_engine_defines.svh"

module vde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result stays offered
  `VDE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")

  // A zero-norm result always carries distance zero
  `VDE_ASSERT(a_zn_zero, out_tvalid && out_tuser |-> out_tdata == 32'd0, "zero_norm with distance")

  // A beat without tlast cannot raise a new result next cycle
  `VDE_ASSERT(a_no_early, in_tvalid && in_tready && !in_tlast && !out_tvalid |=> !out_tvalid, "result without last beat")

  // Reset empties the output register
  `VDE_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind vector_distance_engine vde_checker u_vde_checker (.*);

### sim/vector_distance_engine_tb.sv
// Testbench for vector_distance_engine: streams coordinate pairs, predicts each distance.
// Depends on vde_pkg and the vector_distance_engine RTL; self-checking, no files.
module vector_distance_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] distance;
    logic        zero_norm;
  } dist_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;

  // predictor state
  logic [1:0]  cur_metric;
  logic [47:0] acc_main, acc_na, acc_nb;
  int          acc_count;
  dist_result_t expected_q[$];
  int          fail_count = 0;
  bit          rx_idle_en = 1'b1;
  bit          tx_idle_en = 1'b1;
  int          rx_hold = 0;

  vector_distance_engine uut (.*);

  always #5 clk = ~clk;

  // floor square root of a 48-bit value
  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // update the running sums with one pair; queue a distance on the last pair
  task automatic predict_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    longint sa, sb, d, dot, q, r;
    logic [63:0] term, mag, den;
    dist_result_t res;
    sa = a;
    sb = b;
    if (acc_count < vde_pkg::MAX_DIM) begin
      d = sa - sb;
      term = 0;
      case (cur_metric)
        vde_pkg::METRIC_L2:  term = d * d;
        vde_pkg::METRIC_COS: term = sa * sb;
        vde_pkg::METRIC_MAN: term = (d < 0) ? -d : d;
        default:             term = 0;
      endcase
      acc_main = acc_main + term[47:0];
      acc_na = acc_na + 48'(sa * sa);
      acc_nb = acc_nb + 48'(sb * sb);
      acc_count++;
    end
    if (!last) return;
    res = '0;
    case (cur_metric)
      vde_pkg::METRIC_L2: res.distance = 32'(floor_root({16'd0, acc_main}));
      vde_pkg::METRIC_COS: begin
        if (acc_na == 0 || acc_nb == 0) begin
          res.zero_norm = 1'b1;
        end else begin
          dot = longint'(signed'(acc_main));
          mag = (dot < 0) ? -dot : dot;
          den = floor_root({16'd0, acc_na}) * floor_root({16'd0, acc_nb});
          q = longint'((mag << 12) / den);
          if (dot < 0) q = -q;
          r = 4096 - q;
          if (r < 0) r = 0;
          if (r > 8192) r = 8192;
          res.distance = 32'(r);
        end
      end
      vde_pkg::METRIC_MAN:
        res.distance = (acc_main > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc_main[31:0];
      default: res = '0;
    endcase
    expected_q.push_back(res);
    acc_main = 0;
    acc_na = 0;
    acc_nb = 0;
    acc_count = 0;
  endtask

  // send one beat, with random idle before it; valid stays up for the next beat
  task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
    while (tx_idle_en && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b, a};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pair(a, b, last);
    @(negedge clk);
  endtask

  // drop valid and wait for every expected result
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // write the metric register while idle
  task automatic set_metric(logic [1:0] m);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_metric = m;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(int len);
    for (int i = 0; i < len; i++) send_pair(rand_coord(), rand_coord(), i == len - 1);
  endtask

  // extremes, zero norm, one- and two-pair vectors under every metric
  task automatic test_directed;
    for (int m = 0; m < 4; m++) begin
      set_metric(2'(m));
      send_pair(16'h7FFF, 16'h8000, 1'b1);
      send_pair(16'h0000, 16'h1000, 1'b1);
      send_pair(16'h8000, 16'h8000, 1'b0);
      send_pair(16'hFFFF, 16'h0001, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b1);
    end
  endtask

  // more than MAX_DIM pairs in one vector, with large terms
  task automatic test_overlong;
    set_metric(vde_pkg::METRIC_L2);
    for (int i = 0; i < vde_pkg::MAX_DIM + 3; i++)
      send_pair(16'h8000, 16'h7FFF, i == vde_pkg::MAX_DIM + 2);
  endtask

  // metric switched within a vector
  task automatic test_mixed_metric;
    set_metric(vde_pkg::METRIC_COS);
    send_pair(16'h1000, 16'h2000, 1'b0);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= vde_pkg::METRIC_L2;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_metric = vde_pkg::METRIC_L2;
    send_pair(16'h0800, 16'hF000, 1'b1);
    // a negative dot sum read as Manhattan saturates
    set_metric(vde_pkg::METRIC_COS);
    send_pair(16'h7FFF, 16'h8000, 1'b0);
    set_metric(vde_pkg::METRIC_MAN);
    send_pair(16'h0001, 16'h0000, 1'b1);
  endtask

  // random vectors, mostly short, switching metric now and then
  task automatic test_random(int n_items);
    int sent;
    int next_sw;
    sent = 0;
    next_sw = 0;
    while (sent < n_items) begin
      int len;
      if (sent >= next_sw) begin
        set_metric(2'($urandom_range(3)));
        next_sw += 150;
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
      send_vector(len);
      sent += len;
    end
  endtask

  // receiver holds off while the sender keeps offering; then no idling
  task automatic test_backpressure;
    set_metric(vde_pkg::METRIC_MAN);
    rx_hold = 400;
    send_vector(60);
    for (int i = 0; i < 20; i++) send_vector(1);
    drain();
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    set_metric(vde_pkg::METRIC_COS);
    for (int i = 0; i < 30; i++) send_vector($urandom_range(3, 1));
    drain();
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
  endtask

  // receiver ready pattern
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_idle_en && $urandom_range(99) < 26);
    end
  end

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result distance=%h zero_norm=%b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        dist_result_t exp_r;
        exp_r = expected_q.pop_front();
        if (out_tdata !== exp_r.distance) begin
          $error("distance: expected %h actual %h", exp_r.distance, out_tdata);
          fail_count++;
        end
        if (out_tuser !== exp_r.zero_norm) begin
          $error("zero_norm: expected %b actual %b", exp_r.zero_norm, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cur_metric = vde_pkg::METRIC_L2;
    acc_main = 0;
    acc_na = 0;
    acc_nb = 0;
    acc_count = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_mixed_metric();
    test_overlong();
    test_backpressure();
    test_random(1000);
    drain();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
